// File: rtl/tgr_pkg.sv
// shared constants and types of the 8x8 glyph text renderer
`default_nettype none

package tgr_pkg;

  // display and font geometry
  localparam int SCREEN_WIDTH = 320;
  localparam int GLYPH_COUNT  = 256;
  localparam int FONT_DEPTH   = GLYPH_COUNT * 8;
  localparam int FONT_AW      = $clog2(FONT_DEPTH);

  // field widths
  localparam int COORD_W  = 10;
  localparam int COLOR_W  = 16;
  localparam int ADDR_W   = 11;
  localparam int CODE_W   = 8;
  localparam int ACTION_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ORIGIN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DRAW   = 2'd2;

  // register indexes
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // reset colors
  localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

  // start of one draw item, top to sequencer
  typedef struct packed {
    logic               start;
    logic               newline;
    logic               glyph_ok;
    logic [CODE_W-1:0]  code;
    logic               last_char;
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
  } draw_cmd_t;

  // font memory read request
  typedef struct packed {
    logic               en;
    logic [FONT_AW-1:0] addr;
  } font_rd_t;

endpackage

`default_nettype wire

// File: rtl/tgr_in_if.sv
// input channel of the glyph renderer
`default_nettype none

interface tgr_in_if;
  logic                            valid;
  logic                            ready;
  logic [tgr_pkg::ACTION_W-1:0]    action;
  logic [tgr_pkg::ADDR_W-1:0]      font_address;
  logic [7:0]                      font_byte;
  logic [tgr_pkg::COORD_W-1:0]     origin_x;
  logic [tgr_pkg::COORD_W-1:0]     origin_y;
  logic [tgr_pkg::CODE_W-1:0]      char_code;
  logic                            last_char;

  modport source (output valid, action, font_address, font_byte, origin_x, origin_y,
                  char_code, last_char, input ready);
  modport sink (input valid, action, font_address, font_byte, origin_x, origin_y,
                char_code, last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/tgr_out_if.sv
// pixel output channel of the glyph renderer
`default_nettype none

interface tgr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            pixel_valid;
  logic [tgr_pkg::COLOR_W-1:0]     pixel_color;
  logic [tgr_pkg::COORD_W-1:0]     window_x;
  logic [tgr_pkg::COORD_W-1:0]     window_y;
  logic                            first_pixel;
  logic                            last_pixel;
  logic [tgr_pkg::COORD_W-1:0]     cursor_x;
  logic [tgr_pkg::COORD_W-1:0]     cursor_y;
  logic                            string_end;

  modport source (output valid, pixel_valid, pixel_color, window_x, window_y, first_pixel,
                  last_pixel, cursor_x, cursor_y, string_end, input ready);
  modport sink (input valid, pixel_valid, pixel_color, window_x, window_y, first_pixel,
                last_pixel, cursor_x, cursor_y, string_end, output ready);
endinterface

`default_nettype wire

// File: rtl/tgr_font_mem.sv
// font memory: one write port, one registered read port
`default_nettype none

module tgr_font_mem (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [tgr_pkg::FONT_AW-1:0]   wr_addr,
  input  wire logic [7:0]                    wr_data,
  input  wire tgr_pkg::font_rd_t             rd,
  output      logic [7:0]                    rd_data
);

  logic [7:0] mem [tgr_pkg::FONT_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tgr_seq.sv
// pixel sequencer: row shifter, pixel counter and output register
`default_nettype none

module tgr_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tgr_pkg::draw_cmd_t            cmd,
  input  wire logic [tgr_pkg::COLOR_W-1:0]   fg_color,
  input  wire logic [tgr_pkg::COLOR_W-1:0]   bg_color,
  input  wire logic [7:0]                    rd_data,
  output      tgr_pkg::font_rd_t             rd,
  output      logic                          idle,
  tgr_out_if.source                          dout
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_NL   = 2'd2;

  logic [1:0]                   state;
  logic [5:0]                   pix;
  logic [7:0]                   shreg;
  logic [tgr_pkg::CODE_W-1:0]   code;
  logic                         last_char;
  logic                         glyph_ok;
  logic [tgr_pkg::COORD_W-1:0]  win_x;
  logic [tgr_pkg::COORD_W-1:0]  win_y;
  logic [tgr_pkg::COORD_W-1:0]  cur_x;
  logic [tgr_pkg::COORD_W-1:0]  cur_y;

  logic                         advance;
  logic                         beat_out;
  logic                         row_start;
  logic [7:0]                   row_data;
  logic                         bit_set;
  logic [2:0]                   next_row;
  logic [tgr_pkg::ADDR_W-1:0]   addr_full;

  assign idle      = (state == ST_IDLE);
  assign advance   = !dout.valid || dout.ready;
  assign beat_out  = ((state == ST_RUN) || (state == ST_NL)) && advance;
  assign row_start = (pix[2:0] == 3'd0);
  assign row_data  = glyph_ok ? rd_data : 8'd0;
  assign bit_set   = row_start ? row_data[7] : shreg[7];
  assign next_row  = pix[5:3] + 3'd1;

  // font read: row 0 at start, next row while the current one shifts out
  always_comb begin
    rd.en     = 1'b0;
    addr_full = {code, next_row};
    if (idle && cmd.start && !cmd.newline) begin
      rd.en     = 1'b1;
      addr_full = {cmd.code, 3'd0};
    end else if (state == ST_RUN && advance && row_start && pix[5:3] != 3'd7) begin
      rd.en = 1'b1;
    end
    rd.addr = addr_full[tgr_pkg::FONT_AW-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pix        <= 6'd0;
      dout.valid <= 1'b0;
    end else begin
      // output valid: set on a new beat, cleared once the beat is taken
      if (beat_out) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state <= cmd.newline ? ST_NL : ST_RUN;
            pix   <= 6'd0;
          end
        end
        ST_RUN: begin
          if (advance) begin
            pix <= pix + 6'd1;
            if (pix == 6'd63) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_NL: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item context captured at start
  always_ff @(posedge clk) begin
    if (idle && cmd.start) begin
      code      <= cmd.code;
      last_char <= cmd.last_char;
      glyph_ok  <= cmd.glyph_ok;
      win_x     <= cmd.win_x;
      win_y     <= cmd.win_y;
      cur_x     <= cmd.cur_x;
      cur_y     <= cmd.cur_y;
    end
  end

  // row shifter and output payload
  always_ff @(posedge clk) begin
    if (state == ST_RUN && advance) begin
      shreg            <= row_start ? {row_data[6:0], 1'b0} : {shreg[6:0], 1'b0};
      dout.pixel_valid <= 1'b1;
      dout.pixel_color <= bit_set ? fg_color : bg_color;
      dout.window_x    <= win_x;
      dout.window_y    <= win_y;
      dout.first_pixel <= (pix == 6'd0);
      dout.last_pixel  <= (pix == 6'd63);
      dout.cursor_x    <= cur_x;
      dout.cursor_y    <= cur_y;
      dout.string_end  <= (pix == 6'd63) && last_char;
    end else if (state == ST_NL && advance) begin
      dout.pixel_valid <= 1'b0;
      dout.pixel_color <= '0;
      dout.window_x    <= '0;
      dout.window_y    <= '0;
      dout.first_pixel <= 1'b0;
      dout.last_pixel  <= 1'b1;
      dout.cursor_x    <= cur_x;
      dout.cursor_y    <= cur_y;
      dout.string_end  <= last_char;
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_glyph_renderer_8x8_unit.sv
// top level of the 8x8 bitmap font text renderer
//
// din carries load-font, set-origin and draw items; an item is taken on a beat with
// valid and ready high. A load writes one byte of the 256-glyph font memory, a
// set-origin fixes line start and cursor; both give no result.
// A draw item gives 64 pixel beats on dout, row by row with the leftmost pixel
// first, or one cursor-only beat for a newline. The draw beat takes the sequencer out
// of idle, then the first pixel is registered in the output register and a pixel
// follows every cycle while dout does not stall; meanwhile the pixel counter of the
// sequencer steps once per pixel while the font read of the next row overlaps.
// din.ready is low while a character is being sent out. When dout stalls, the output
// register holds its beat and the sequencer waits. Colors are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is idle, which
// the block does not enforce. Synchronous reset clears the cursor, the line start and
// the colors to white on black; font memory content is undefined until loaded.
`default_nettype none

module text_glyph_renderer_8x8_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tgr_in_if.sink                             din,
  tgr_out_if.source                          dout,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tgr_pkg::COLOR_W-1:0]   cfg_data
);

  logic [tgr_pkg::COLOR_W-1:0]  fg_color;
  logic [tgr_pkg::COLOR_W-1:0]  bg_color;
  logic [tgr_pkg::COORD_W-1:0]  line_start_x;
  logic [tgr_pkg::COORD_W-1:0]  cursor_col;
  logic [tgr_pkg::COORD_W-1:0]  cursor_row;
  logic [tgr_pkg::COORD_W-1:0]  cursor_col_next;
  logic [tgr_pkg::COORD_W-1:0]  cursor_row_next;

  logic                         accept;
  logic                         is_draw;
  logic                         newline;
  logic                         wrap;
  logic [tgr_pkg::COORD_W-1:0]  base_col;
  logic [tgr_pkg::COORD_W-1:0]  base_row;
  logic                         font_wr;
  logic                         idle;
  logic [7:0]                   rd_data;
  tgr_pkg::draw_cmd_t           cmd;
  tgr_pkg::font_rd_t            rd;

  assign din.ready = idle;
  assign accept    = din.valid && din.ready;
  assign is_draw   = (din.action == tgr_pkg::ACT_DRAW);

  // color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tgr_pkg::FG_RESET;
      bg_color <= tgr_pkg::BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgr_pkg::REG_FG: fg_color <= cfg_data;
        tgr_pkg::REG_BG: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // line wrap and cursor advance for a draw item
  always_comb begin
    newline  = (din.char_code == tgr_pkg::NEWLINE_CODE);
    wrap     = newline ||
               (cursor_col >= tgr_pkg::COORD_W'(tgr_pkg::SCREEN_WIDTH - 8));
    base_col = wrap ? line_start_x : cursor_col;
    base_row = wrap ? cursor_row + tgr_pkg::COORD_W'(8) : cursor_row;
    cursor_col_next = newline ? base_col : base_col + tgr_pkg::COORD_W'(8);
    cursor_row_next = base_row;
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_start_x <= '0;
      cursor_col   <= '0;
      cursor_row   <= '0;
    end else if (accept) begin
      if (din.action == tgr_pkg::ACT_ORIGIN) begin
        line_start_x <= din.origin_x;
        cursor_col   <= din.origin_x;
        cursor_row   <= din.origin_y;
      end else if (is_draw) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
    end
  end

  // command to the sequencer
  always_comb begin
    cmd.start     = accept && is_draw;
    cmd.newline   = newline;
    cmd.glyph_ok  = {1'b0, din.char_code} < 9'(tgr_pkg::GLYPH_COUNT);
    cmd.code      = din.char_code;
    cmd.last_char = din.last_char;
    cmd.win_x     = base_col;
    cmd.win_y     = base_row;
    cmd.cur_x     = cursor_col_next;
    cmd.cur_y     = cursor_row_next;
  end

  // font load, ignored beyond the glyph range
  assign font_wr = accept && (din.action == tgr_pkg::ACT_LOAD) &&
                   ({1'b0, din.font_address} < 12'(tgr_pkg::FONT_DEPTH));

  tgr_font_mem u_font_mem (
    .clk     (clk),
    .wr_en   (font_wr),
    .wr_addr (din.font_address[tgr_pkg::FONT_AW-1:0]),
    .wr_data (din.font_byte),
    .rd      (rd),
    .rd_data (rd_data)
  );

  tgr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .rd_data  (rd_data),
    .rd       (rd),
    .idle     (idle),
    .dout     (dout)
  );

`ifndef SYNTHESIS
  // a draw beat keeps the block busy on the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    accept && is_draw |=> !din.ready)
    else $error("input ready right after a draw beat");

  // a cursor-only beat carries no window and closes its item
  a_newline_beat: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.pixel_valid |->
      dout.last_pixel && !dout.first_pixel && dout.window_x == '0 && dout.window_y == '0)
    else $error("malformed newline beat");

  // string end only on the last beat of an item
  a_string_end: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.string_end |-> dout.last_pixel)
    else $error("string end away from last beat");

  // no new item while a beat other than the last of an item waits on dout
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.last_pixel |-> !din.ready)
    else $error("input ready in the middle of a glyph");
`endif

endmodule

`default_nettype wire
